// ===== rtl/sha1md_pkg.sv =====
// Shared types, constants and round functions of the SHA-1 message digest block.
package sha1md_pkg;

	typedef logic [31:0] word_t;
	typedef logic [4:0][31:0] chain_t;
	typedef logic [6:0] round_t;

	localparam word_t K_R0 = 32'h5A827999;
	localparam word_t K_R1 = 32'h6ED9EBA1;
	localparam word_t K_R2 = 32'h8F1BBCDC;
	localparam word_t K_R3 = 32'hCA62C1D6;
	localparam word_t PAD_WORD = 32'h8000_0000;
	localparam round_t LAST_ROUND = 7'd79;

	localparam chain_t CHAIN_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	typedef struct packed {
		logic push;
		logic start;
		logic init;
	} core_ctrl_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_COMP = 5'b00010,
		ST_PAD  = 5'b00100,
		ST_DONE = 5'b01000,
		ST_SPARE = 5'b10000
	} state_t;

	function automatic word_t round_f(round_t rnd, word_t b, word_t c, word_t d);
		word_t f;
		if (rnd < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (rnd < 7'd40) begin
			f = b ^ c ^ d;
		end else if (rnd < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

	function automatic word_t round_k(round_t rnd);
		word_t k;
		if (rnd < 7'd20) begin
			k = K_R0;
		end else if (rnd < 7'd40) begin
			k = K_R1;
		end else if (rnd < 7'd60) begin
			k = K_R2;
		end else begin
			k = K_R3;
		end
		return k;
	endfunction

endpackage

// ===== rtl/sha1md_in_if.sv =====
// Request channel carrying message words into the digest block.
interface sha1md_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        last_word;

	modport source (output valid, output data_word, output byte_count, output last_word,
		input ready);
	modport sink (input valid, input data_word, input byte_count, input last_word,
		output ready);
endinterface

// ===== rtl/sha1md_out_if.sv =====
// Request channel carrying the 160-bit digest out of the block.
interface sha1md_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word0;
	logic [31:0] digest_word1;
	logic [31:0] digest_word2;
	logic [31:0] digest_word3;
	logic [31:0] digest_word4;

	modport source (output valid, output digest_word0, output digest_word1,
		output digest_word2, output digest_word3, output digest_word4, input ready);
	modport sink (input valid, input digest_word0, input digest_word1,
		input digest_word2, input digest_word3, input digest_word4, output ready);
endinterface

// ===== rtl/sha1_message_digest.sv =====
// Top level of the SHA-1 message digest block: word intake, padding sequencer, digest output.
//
// Message words are taken one per cycle until sixteen have filled the block buffer; the
// sixteenth starts a compression that runs one round per cycle in a single shared round unit,
// 80 rounds and then a fold of the result into the chaining words, during which no word is
// taken. The last word starts the padding sequencer, which pushes one pad word per cycle (up to
// sixteen per block) through the same buffer and compresses one or two final blocks before the
// digest is registered on the output channel. A new message may start while a digest still waits
// to be taken.
module sha1_message_digest
	import sha1md_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	sha1md_in_if.sink    msg,
	sha1md_out_if.source dig
);

	state_t     state_q, state_nx;
	logic [3:0] pos_q;
	logic [63:0] bitlen_q;
	logic       lastm_q;
	logic       padp_q;
	logic       hid_q;
	logic       fin_q;
	logic       dig_vld_q;
	chain_t     dig_q;
	core_ctrl_t ctrl;
	word_t      word;
	logic       done;
	chain_t     chain;
	logic       take;
	logic       out_free;
	logic [2:0] nc;
	word_t      last_w;

	sha1md_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.word   (word),
		.done   (done),
		.chain  (chain)
	);

	assign msg.ready = (state_q == ST_IDLE);
	assign take      = msg.valid && msg.ready;
	assign out_free  = !dig_vld_q || dig.ready;
	assign nc        = (msg.byte_count > 3'd4) ? 3'd4 : msg.byte_count;

	always_comb begin
		case (nc)
			3'd0:    last_w = PAD_WORD;
			3'd1:    last_w = {msg.data_word[31:24], 24'h800000};
			3'd2:    last_w = {msg.data_word[31:16], 16'h8000};
			3'd3:    last_w = {msg.data_word[31:8], 8'h80};
			default: last_w = msg.data_word;
		endcase
	end

	always_comb begin
		ctrl     = '0;
		word     = msg.data_word;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					ctrl.push  = 1'b1;
					ctrl.start = (pos_q == 4'd15);
					word       = msg.last_word ? last_w : msg.data_word;
					if (pos_q == 4'd15) begin
						state_nx = ST_COMP;
					end else if (msg.last_word) begin
						state_nx = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				ctrl.push  = 1'b1;
				ctrl.start = (pos_q == 4'd15);
				if (padp_q) begin
					word = PAD_WORD;
				end else if (pos_q == 4'd14 && !hid_q) begin
					word = bitlen_q[63:32];
				end else if (pos_q == 4'd15 && hid_q) begin
					word = bitlen_q[31:0];
				end else begin
					word = '0;
				end
				if (pos_q == 4'd15) begin
					state_nx = ST_COMP;
				end
			end
			ST_COMP: begin
				if (done) begin
					if (fin_q) begin
						state_nx = ST_DONE;
					end else if (lastm_q) begin
						state_nx = ST_PAD;
					end else begin
						state_nx = ST_IDLE;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					ctrl.init = 1'b1;
					state_nx  = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			bitlen_q  <= '0;
			lastm_q   <= 1'b0;
			padp_q    <= 1'b0;
			hid_q     <= 1'b0;
			fin_q     <= 1'b0;
			dig_vld_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ctrl.push) begin
				pos_q <= pos_q + 4'd1;
			end
			if (take) begin
				lastm_q  <= msg.last_word;
				padp_q   <= msg.last_word && (nc == 3'd4);
				bitlen_q <= bitlen_q + (msg.last_word ? {58'd0, nc, 3'd0} : 64'd32);
			end
			if (state_q == ST_PAD) begin
				if (padp_q) begin
					padp_q <= 1'b0;
				end else if (pos_q == 4'd14 && !hid_q) begin
					hid_q <= 1'b1;
				end else if (pos_q == 4'd15 && hid_q) begin
					fin_q <= 1'b1;
				end
			end
			if (dig_vld_q && dig.ready) begin
				dig_vld_q <= 1'b0;
			end
			if (ctrl.init) begin
				dig_vld_q <= 1'b1;
				bitlen_q  <= '0;
				lastm_q   <= 1'b0;
				hid_q     <= 1'b0;
				fin_q     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			dig_q <= chain;
		end
	end

	assign dig.valid        = dig_vld_q;
	assign dig.digest_word0 = dig_q[0];
	assign dig.digest_word1 = dig_q[1];
	assign dig.digest_word2 = dig_q[2];
	assign dig.digest_word3 = dig_q[3];
	assign dig.digest_word4 = dig_q[4];

endmodule

// ===== rtl/sha1md_core.sv =====
// Block buffer, message schedule and one-round-per-cycle compression unit.
module sha1md_core
	import sha1md_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  core_ctrl_t ctrl,
	input  word_t      word,
	output logic       done,
	output chain_t     chain
);

	word_t  w_q [16];
	word_t  a_q, b_q, c_q, d_q, e_q;
	round_t rnd_q;
	logic   busy_q;
	logic   add_q;
	chain_t chain_q;
	word_t  w_new;
	word_t  t_sum;

	assign w_new = {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
		w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};
	assign t_sum = {a_q[26:0], a_q[31:27]} + round_f(rnd_q, b_q, c_q, d_q) + e_q
		+ round_k(rnd_q) + w_q[0];

	always_ff @(posedge clk) begin
		if (ctrl.push || busy_q) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= ctrl.push ? word : w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (busy_q) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			add_q  <= 1'b0;
			rnd_q  <= '0;
		end else begin
			add_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				if (rnd_q == LAST_ROUND) begin
					busy_q <= 1'b0;
					add_q  <= 1'b1;
					rnd_q  <= '0;
				end else begin
					rnd_q <= rnd_q + 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= CHAIN_INIT;
		end else if (ctrl.init) begin
			chain_q <= CHAIN_INIT;
		end else if (add_q) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
			chain_q[4] <= chain_q[4] + e_q;
		end
	end

	assign done  = add_q;
	assign chain = chain_q;

	a_no_push_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |-> !busy_q && !add_q)
		else $error("word pushed while compression runs");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rnd_q <= LAST_ROUND)
		else $error("round counter out of range");

	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(ctrl.start))
		else $error("compression began without start");

	a_add_after_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		add_q |-> $past(busy_q) && $past(rnd_q) == LAST_ROUND)
		else $error("chain update outside end of rounds");

endmodule
